FILE: src/mlbs_pkg.sv
// Shared constants, command codes and the controller-to-datapath command
// bundle for the multi-LED blink sequencer. No dependencies.
package mlbs_pkg;

	localparam int NUM_LEDS  = 16;
	localparam int MAX_STEPS = 8;

	// Field widths fixed by the item format
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 4;
	localparam int COUNT_W  = 8;
	localparam int SIDX_W   = 3;
	localparam int DUR_W    = 8;
	localparam int MASK_W   = 16;
	localparam int DRIVE_W  = 16;

	// Per-LED state widths
	localparam int LEN_W    = 4;
	localparam int POS_W    = 4;
	localparam int TICK_W   = 8;

	localparam int LED_AW    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int RAM_DEPTH = NUM_LEDS * MAX_STEPS;
	localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_ENABLE = 2'd1,
		CMD_HEADER = 2'd2,
		CMD_STEP   = 2'd3
	} command_t;

	typedef struct packed {
		logic              accept;    // item taken this cycle
		logic              issue;     // start duration read for issue_idx
		logic [LED_AW-1:0] issue_idx;
		logic              proc;      // update LED proc_idx with read data
		logic [LED_AW-1:0] proc_idx;
		logic              load_out;  // capture drive into output register
	} mlbs_cmd_t;

endpackage

FILE: src/mlbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/mlbs_ctrl.sv
// Sequencer controller: accepts items, sweeps the LEDs on a tick and
// manages the output register. Depends on mlbs_pkg.
module mlbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mlbs_pkg::CMD_W-1:0]    command,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mlbs_pkg::mlbs_cmd_t           cmd
);
	import mlbs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [LED_AW-1:0] cnt_q;
	logic              proc_s1;
	logic [LED_AW-1:0] proc_idx_s1;
	logic              out_valid_q;
	logic              accept;
	logic              issue;
	logic              load_out;
	logic              last_led;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_led = (cnt_q == LED_AW'(NUM_LEDS - 1));

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (command == CMD_TICK) ? ST_SWEEP : ST_DONE;
				end
			end
			ST_SWEEP: begin
				issue = 1'b1;
				if (last_led) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output slot is free
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			proc_s1     <= 1'b0;
			proc_idx_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			proc_s1     <= issue;
			proc_idx_s1 <= cnt_q;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue && !last_led) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cmd.accept    = accept;
	assign cmd.issue     = issue;
	assign cmd.issue_idx = cnt_q;
	assign cmd.proc      = proc_s1;
	assign cmd.proc_idx  = proc_idx_s1;
	assign cmd.load_out  = load_out;

endmodule

FILE: src/mlbs_dp.sv
// Sequencer datapath: per-LED pattern and run state, step duration RAM,
// the per-LED step update and the output register. Depends on mlbs_pkg
// and mlbs_ram.
module mlbs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlbs_pkg::mlbs_cmd_t             cmd,
	input  logic [mlbs_pkg::CMD_W-1:0]      command,
	input  logic [mlbs_pkg::IDX_W-1:0]      led_index,
	input  logic                            first_on,
	input  logic [mlbs_pkg::COUNT_W-1:0]    step_count,
	input  logic [mlbs_pkg::SIDX_W-1:0]     step_index,
	input  logic [mlbs_pkg::DUR_W-1:0]      duration,
	input  logic [mlbs_pkg::MASK_W-1:0]     enable_mask,
	output logic [mlbs_pkg::DRIVE_W-1:0]    led_drive_n
);
	import mlbs_pkg::*;

	logic [NUM_LEDS-1:0]  enabled_q;
	logic [NUM_LEDS-1:0]  start_on_q;
	logic [NUM_LEDS-1:0]  lit_q;
	logic [NUM_LEDS-1:0]  started_q;
	logic [LEN_W-1:0]     len_q  [NUM_LEDS];
	logic [POS_W-1:0]     pos_q  [NUM_LEDS];
	logic [TICK_W-1:0]    tick_q [NUM_LEDS];
	logic [RAM_DEPTH-1:0] dur_vld_q;
	logic                 dur_vld_s1;
	logic [DRIVE_W-1:0]   drive_q;

	logic              led_ok;
	logic [LED_AW-1:0] wled;
	logic              hdr_we;
	logic              dur_we;
	logic [RAM_AW-1:0] waddr;
	logic [RAM_AW-1:0] raddr;
	logic [LEN_W-1:0]  len_sat;
	logic [POS_W-1:0]  issue_pos;
	logic [DUR_W-1:0]  rdata;
	logic [DUR_W-1:0]  dur;

	logic [LED_AW-1:0] pi;
	logic [LEN_W-1:0]  p_len;
	logic              p_wrap;
	logic [POS_W-1:0]  p_pos0, p_pos1, pos_n;
	logic [TICK_W-1:0] p_tick0, tick_n;
	logic              p_lit0, lit_n, started_n;

	// Writes
	assign led_ok  = ({1'b0, led_index} < (IDX_W + 1)'(NUM_LEDS));
	assign wled    = led_index[LED_AW-1:0];
	assign hdr_we  = cmd.accept && (command == CMD_HEADER) && led_ok;
	assign dur_we  = cmd.accept && (command == CMD_STEP) && led_ok &&
		({1'b0, step_index} < (SIDX_W + 1)'(MAX_STEPS));
	assign waddr   = RAM_AW'(int'(wled) * MAX_STEPS + int'(step_index));
	assign len_sat = (step_count > COUNT_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
		: step_count[LEN_W-1:0];

	// A position at or past the length restarts at step zero
	assign issue_pos = (pos_q[cmd.issue_idx] >= POS_W'(len_q[cmd.issue_idx])) ? '0
		: pos_q[cmd.issue_idx];
	assign raddr = RAM_AW'(int'(cmd.issue_idx) * MAX_STEPS + int'(issue_pos));

	mlbs_ram #(
		.WIDTH (DUR_W),
		.DEPTH (RAM_DEPTH)
	) u_dur_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (waddr),
		.wdata (duration),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Never-written entries read as zero
	assign dur = dur_vld_s1 ? rdata : '0;

	// Step update for the LED in the process stage
	always_comb begin
		pi        = cmd.proc_idx;
		p_len     = len_q[pi];
		p_wrap    = (pos_q[pi] >= POS_W'(p_len));
		p_pos0    = p_wrap ? '0 : pos_q[pi];
		p_tick0   = p_wrap ? '0 : tick_q[pi];
		p_lit0    = (p_wrap || !started_q[pi]) ? start_on_q[pi] : lit_q[pi];
		pos_n     = pos_q[pi];
		tick_n    = tick_q[pi];
		lit_n     = lit_q[pi];
		started_n = started_q[pi];
		p_pos1    = p_pos0;
		if (!enabled_q[pi]) begin
			pos_n     = '0;
			tick_n    = '0;
			started_n = 1'b0;
		end else if (p_len != '0) begin
			lit_n = p_lit0;
			if (p_tick0 < dur) begin
				tick_n = p_tick0 + 1'b1;
			end else begin
				tick_n = '0;
				p_pos1 = p_pos0 + 1'b1;
				lit_n  = !p_lit0;
			end
			if (p_pos1 >= POS_W'(p_len)) begin
				pos_n     = '0;
				tick_n    = '0;
				started_n = 1'b0;
			end else begin
				pos_n     = p_pos1;
				started_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= '0;
			start_on_q <= '0;
			lit_q      <= '0;
			started_q  <= '0;
			len_q      <= '{default: '0};
			pos_q      <= '{default: '0};
			tick_q     <= '{default: '0};
			dur_vld_q  <= '0;
			dur_vld_s1 <= 1'b0;
		end else begin
			if (cmd.accept && (command == CMD_ENABLE)) begin
				enabled_q <= enable_mask[NUM_LEDS-1:0];
			end
			if (hdr_we) begin
				start_on_q[wled] <= first_on;
				len_q[wled]      <= len_sat;
			end
			if (dur_we) begin
				dur_vld_q[waddr] <= 1'b1;
			end
			if (cmd.issue) begin
				dur_vld_s1 <= dur_vld_q[raddr];
			end
			if (cmd.proc) begin
				pos_q[pi]     <= pos_n;
				tick_q[pi]    <= tick_n;
				lit_q[pi]     <= lit_n;
				started_q[pi] <= started_n;
			end
		end
	end

	// LEDs past NUM_LEDS stay dark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '1;
		end else if (cmd.load_out) begin
			drive_q <= ~DRIVE_W'(lit_q);
		end
	end

	assign led_drive_n = drive_q;

endmodule

FILE: src/multi_led_blink_sequencer_unit.sv
// Each item is a command: a tick, an enable mask write, a pattern header
// write or a step duration write, and each gives one item on the output:
// the active-low LED drive after the command. Header, enable and duration
// writes go straight to DONE on acceptance. A tick walks the 16 LEDs one
// per cycle through a two-stage read/update pipeline on the single read
// port of the step duration RAM, then drains; DONE holds each result until
// the output slot is free. One item is in work at a time; the next item
// is taken as soon as the previous one is loaded into the output register,
// even while that result still waits. The drive reads 0xFFFF after reset.
module multi_led_blink_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mlbs_pkg::CMD_W-1:0]      command,
	input  logic [mlbs_pkg::IDX_W-1:0]      led_index,
	input  logic                            first_on,
	input  logic [mlbs_pkg::COUNT_W-1:0]    step_count,
	input  logic [mlbs_pkg::SIDX_W-1:0]     step_index,
	input  logic [mlbs_pkg::DUR_W-1:0]      duration,
	input  logic [mlbs_pkg::MASK_W-1:0]     enable_mask,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mlbs_pkg::DRIVE_W-1:0]    led_drive_n
);
	import mlbs_pkg::*;

	mlbs_cmd_t cmd;

	mlbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mlbs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.command     (command),
		.led_index   (led_index),
		.first_on    (first_on),
		.step_count  (step_count),
		.step_index  (step_index),
		.duration    (duration),
		.enable_mask (enable_mask),
		.led_drive_n (led_drive_n)
	);

	// A tick blocks new items while the sweep runs
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (command == CMD_TICK)) |=> !in_ready)
		else $error("item accepted during LED sweep");

	// Every issued read is processed on the next cycle
	a_issue_proc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> (cmd.proc && (cmd.proc_idx == $past(cmd.issue_idx))))
		else $error("duration read not followed by LED update");

	// The output register is loaded only after the sweep has drained
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!cmd.proc && !cmd.issue && !in_ready))
		else $error("output loaded while LED update in flight");

endmodule
